// ----- rtl/btsw_pkg.sv -----
// ----------------------------------------------------------------------------
// btsw_pkg
// Shared types and constants of the bilinear texture sampler with wrap.
// ----------------------------------------------------------------------------
package btsw_pkg;

    localparam int MaxWidth   = 256;
    localparam int MaxHeight  = 256;
    localparam int XW         = $clog2(MaxWidth);
    localparam int YW         = $clog2(MaxHeight);
    localparam int AW         = XW + YW;
    localparam int SizeW      = 9;
    localparam int ChW        = 16;
    localparam int TexelW     = 3 * ChW;

    localparam logic [0:0] OpWrite  = 1'b0;
    localparam logic [0:0] OpSample = 1'b1;

    localparam logic RegWidth  = 1'b0;
    localparam logic RegHeight = 1'b1;

    typedef logic [ChW-1:0] t_ch;
    typedef logic [AW-1:0]  t_addr;

    typedef struct packed {
        t_ch red;
        t_ch green;
        t_ch blue;
    } t_texel;

    // one store access issued by the sequencer toward the blend unit
    typedef struct packed {
        logic       valid;
        logic [1:0] tap;
        logic       last;
        logic [16:0] wu;
        logic [16:0] wv;
    } t_tap_ctl;

    function automatic logic [12:0] eff_size(input logic [SizeW-1:0] r, input int maxv);
        logic [12:0] m;
        begin
            m = 13'(maxv);
            if (r == '0) eff_size = 13'd1;
            else if ({4'd0, r} > m) eff_size = m;
            else eff_size = {4'd0, r};
        end
    endfunction

endpackage

// ----- rtl/btsw_store.sv -----
// ----------------------------------------------------------------------------
// btsw_store
// Single-port texel memory, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module btsw_store (
    input  logic              i_clk,
    input  logic              i_we,
    input  btsw_pkg::t_addr   i_addr,
    input  btsw_pkg::t_texel  i_wdata,
    output btsw_pkg::t_texel  o_rdata
);

    btsw_pkg::t_texel r_mem [0:(1 << btsw_pkg::AW)-1];
    btsw_pkg::t_texel r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/btsw_blend.sv -----
// ----------------------------------------------------------------------------
// btsw_blend
// Weight and accumulate four fetched texels per sample.
// ----------------------------------------------------------------------------
module btsw_blend (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  btsw_pkg::t_tap_ctl  i_ctl,
    input  btsw_pkg::t_texel    i_texel,
    output logic                o_done,
    output btsw_pkg::t_texel    o_result
);

    btsw_pkg::t_tap_ctl r_ctl0, r_ctl2;
    logic [32:0] r_w;
    logic [48:0] r_pr, r_pg, r_pb;
    logic [49:0] r_ar, r_ag, r_ab;
    logic [49:0] n_ar, n_ag, n_ab;
    logic        r_done;
    btsw_pkg::t_texel r_res;
    logic [16:0] n_fa, n_fb;

    always_comb begin
        unique case (i_ctl.tap)
            2'd0: begin n_fa = 17'h10000 - i_ctl.wu; n_fb = 17'h10000 - i_ctl.wv; end
            2'd1: begin n_fa = 17'h10000 - i_ctl.wu; n_fb = i_ctl.wv; end
            2'd2: begin n_fa = i_ctl.wu; n_fb = 17'h10000 - i_ctl.wv; end
            default: begin n_fa = i_ctl.wu; n_fb = i_ctl.wv; end
        endcase
    end

    // tap weight lands together with the store read data
    always_ff @(posedge i_clk) begin
        r_w <= 33'(n_fa * n_fb);
        r_pr <= r_w * {17'd0, i_texel.red};
        r_pg <= r_w * {17'd0, i_texel.green};
        r_pb <= r_w * {17'd0, i_texel.blue};
        r_ar <= n_ar;
        r_ag <= n_ag;
        r_ab <= n_ab;
        if (r_ctl2.valid && r_ctl2.last) begin
            r_res <= '{red: n_ar[47:32], green: n_ag[47:32], blue: n_ab[47:32]};
        end
    end

    // r_ctl2: accumulate stage, lines up with the products
    always_comb begin
        n_ar = (r_ctl2.tap == 2'd0) ? 50'(r_pr) : r_ar + 50'(r_pr);
        n_ag = (r_ctl2.tap == 2'd0) ? 50'(r_pg) : r_ag + 50'(r_pg);
        n_ab = (r_ctl2.tap == 2'd0) ? 50'(r_pb) : r_ab + 50'(r_pb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl0 <= '0;
            r_ctl2 <= '0;
            r_done <= 1'b0;
        end else begin
            r_ctl0 <= i_ctl;
            r_ctl2 <= r_ctl0;
            r_done <= r_ctl2.valid && r_ctl2.last;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

// ----- rtl/bilinear_texture_sampler_wrap_unit.sv -----
// ----------------------------------------------------------------------------
// bilinear_texture_sampler_wrap_unit
// Texel store with bilinear sampling and wrap addressing.
//
//   channel | handshake          | payload
//   input   | i_valid / o_stall  | op, texel x/y, rgb, u/v
//   output  | o_valid / i_stall  | rgb
//
// A write reaches the store port when accepted; a sample fetches its four
// neighbours in turn, then its result is weighted, summed and queued.
// Reset clears control only; texels are undefined until written.
// The input stalls while a sample fetches or while results in flight could
// overflow the four-entry output queue.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler_wrap_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [8:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [7:0]  i_texel_x,
    input  logic [7:0]  i_texel_y,
    input  logic [15:0] i_in_red,
    input  logic [15:0] i_in_green,
    input  logic [15:0] i_in_blue,
    input  logic [15:0] i_u_coord,
    input  logic [15:0] i_v_coord,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_out_red,
    output logic [15:0] o_out_green,
    output logic [15:0] o_out_blue
);

    logic [8:0] r_width, r_height;
    logic [12:0] w_eff, h_eff;
    logic [1:0]  r_tap;
    logic        r_busy;
    logic [7:0]  r_x0, r_x1, r_y0, r_y1;
    logic [16:0] r_fu, r_fv;
    logic [28:0] up, vp;
    logic [8:0]  x0p, y0p;
    logic        accept;
    logic [2:0]  r_cnt;
    logic        pop;
    logic        done;
    btsw_pkg::t_texel res;
    btsw_pkg::t_tap_ctl ctl;
    logic        we;
    btsw_pkg::t_addr addr;
    btsw_pkg::t_texel rdata;
    btsw_pkg::t_texel r_q [0:3];
    logic [1:0]  r_wp, r_rp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 9'd256;
            r_height <= 9'd256;
        end else if (i_cfg_we) begin
            if (i_cfg_index == btsw_pkg::RegWidth) r_width <= i_cfg_data;
            else r_height <= i_cfg_data;
        end
    end

    assign w_eff = btsw_pkg::eff_size(r_width, btsw_pkg::MaxWidth);
    assign h_eff = btsw_pkg::eff_size(r_height, btsw_pkg::MaxHeight);
    assign up  = 29'({13'd0, i_u_coord} * 29'(w_eff));
    assign vp  = 29'({13'd0, i_v_coord} * 29'(h_eff));
    assign x0p = 9'(up[28:16]) + 9'd1;
    assign y0p = 9'(vp[28:16]) + 9'd1;

    // results outstanding: queued plus in flight must stay within three
    assign o_stall = r_busy || (r_cnt >= 3'd3);
    assign accept  = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_tap  <= 2'd0;
        end else if (accept && i_op == btsw_pkg::OpSample) begin
            r_busy <= 1'b1;
            r_tap  <= 2'd1;
        end else if (r_busy) begin
            r_tap  <= r_tap + 2'd1;
            r_busy <= (r_tap != 2'd3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_op == btsw_pkg::OpSample) begin
            r_x0 <= up[23:16];
            r_y0 <= vp[23:16];
            r_x1 <= ({4'd0, x0p} >= w_eff) ? 8'd0 : x0p[7:0];
            r_y1 <= ({4'd0, y0p} >= h_eff) ? 8'd0 : y0p[7:0];
            r_fu <= {1'b0, up[15:0]};
            r_fv <= {1'b0, vp[15:0]};
        end
    end

    always_comb begin
        we   = 1'b0;
        addr = {i_texel_y, i_texel_x};
        ctl  = '0;
        if (r_busy) begin
            unique case (r_tap)
                2'd1: addr = {r_y1, r_x0};
                2'd2: addr = {r_y0, r_x1};
                default: addr = {r_y1, r_x1};
            endcase
            ctl = '{valid: 1'b1, tap: r_tap, last: (r_tap == 2'd3), wu: r_fu, wv: r_fv};
        end else if (accept && i_op == btsw_pkg::OpSample) begin
            addr = {vp[23:16], up[23:16]};
            ctl  = '{valid: 1'b1, tap: 2'd0, last: 1'b0,
                     wu: {1'b0, up[15:0]}, wv: {1'b0, vp[15:0]}};
        end else if (accept) begin
            we = ({5'd0, i_texel_x} < w_eff) && ({5'd0, i_texel_y} < h_eff);
        end
    end

    btsw_store u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_addr  (addr),
        .i_wdata ('{red: i_in_red, green: i_in_green, blue: i_in_blue}),
        .o_rdata (rdata)
    );

    btsw_blend u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_texel  (rdata),
        .o_done   (done),
        .o_result (res)
    );

    // r_cnt counts samples accepted and not yet transferred out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= '0;
            r_rp  <= '0;
        end else begin
            r_cnt <= r_cnt + 3'(accept && i_op == btsw_pkg::OpSample) - 3'(pop);
            if (done) r_wp <= r_wp + 2'd1;
            if (pop)  r_rp <= r_rp + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) r_q[r_wp] <= res;
    end

    assign o_valid     = (r_wp != r_rp);
    assign o_out_red   = r_q[r_rp].red;
    assign o_out_green = r_q[r_rp].green;
    assign o_out_blue  = r_q[r_rp].blue;

endmodule

// ----- rtl/btsw_checker.sv -----
// ----------------------------------------------------------------------------
// btsw_checker
// Port-level checks of the texture sampler.
// ----------------------------------------------------------------------------
module btsw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_op,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_out_red
);

    a_sample_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_op) |=> o_stall) else $error("sample not held off");

    a_fetch_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_op) |=> ##2 o_stall) else $error("fetch span short");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out_red))) else $error("output dropped");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("valid after reset");

endmodule

bind bilinear_texture_sampler_wrap_unit btsw_checker u_btsw_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_stall   (o_stall),
    .i_op      (i_op),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_out_red (o_out_red)
);
